// ===== hdl/tdpt_pkg.sv =====
// Package for the trial-division prime tester: sizes, constants, request
// structs, sequencer states and the remainder-unit status struct.
// No dependencies.
`default_nettype none

package tdpt_pkg;

    // Table geometry and value width
    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned VALUE_WIDTH = 16;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SQ_W        = 2 * VALUE_WIDTH;
    localparam int unsigned BIT_W       = $clog2(VALUE_WIDTH);
    localparam int unsigned PS_W        = 7;

    // First trial divisor (also the smallest prime) and its square
    localparam int unsigned FIRST_DIV_INT = 2;
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(FIRST_DIV_INT);
    localparam logic [SQ_W-1:0] FIRST_SQUARE = SQ_W'(FIRST_DIV_INT * FIRST_DIV_INT);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] candidate;
    } t_cand_req;

    typedef struct packed {
        logic            is_prime;
        logic [PS_W-1:0] primes_stored;
        logic            undetermined;
    } t_res_req;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_READ,
        S_LOAD,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/tdpt_ifs.sv =====
// Valid/ready channel interfaces for candidate requests and result requests.
// Depends on tdpt_pkg.
`default_nettype none

interface tdpt_cand_if;
    import tdpt_pkg::*;
    logic      valid;
    logic      ready;
    t_cand_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdpt_res_if;
    import tdpt_pkg::*;
    logic     valid;
    logic     ready;
    t_res_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdpt_rem.sv =====
// Bit-serial remainder unit: one restoring step per cycle, dividend MSB first.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_rem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0] i_divisor,
    output tdpt_pkg::t_rem_status                o_status
);
    import tdpt_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [BIT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic [VALUE_WIDTH-1:0] n_rem;

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = trial >= {1'b0, i_divisor};
        n_rem = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    end

    // Control: stay busy until every dividend bit has been stepped, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load on start, advance one bit per busy cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= BIT_W'(VALUE_WIDTH - 1);
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

// ===== hdl/trial_division_prime_tester.sv =====
// Trial-division prime tester: sequencer, prime table memory and result register.
// Depends on tdpt_pkg, tdpt_ifs and tdpt_rem.
//
// Usage:
//   i_cand carries one candidate per request; o_res returns one result per
//   candidate: is_prime, primes_stored (table count after this candidate,
//   low 7 bits) and undetermined (table ran out before the divisor square
//   passed the candidate; the verdict is then not reliable).
//   Feed candidates in ascending order from 2 so the table fills with primes.
//   The candidate is divided by 2, then by each stored prime in turn, until a
//   divisor squared exceeds it, a divisor leaves no remainder, or the table
//   is used up. Each divisor, 2 included, goes through a bound check, the
//   16-step bit-serial remainder, a table read and a load with squaring.
//   Candidates 0 and 1 finish without a remainder; the largest 16-bit
//   primes take 55 remainders. One candidate is in work at a time; the next
//   can be taken in the cycle after the result has moved into the output
//   register, even while the receiver has not yet taken it. Reset empties
//   the table (count to zero) and drops any pending result; only filled
//   entries are read, so no clearing pass. When the receiver stalls, the
//   finished result waits in the sequencer.
`default_nettype none

module trial_division_prime_tester (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdpt_cand_if.sink   i_cand,
    tdpt_res_if.source  o_res
);
    import tdpt_pkg::*;

    // Sequencer and control state
    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    t_res_req               r_out;

    // Per-candidate working registers
    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [SQ_W-1:0]        r_sq;
    logic [CNT_W-1:0]       r_idx;
    logic                   r_verdict;
    logic                   r_unknown;
    logic [VALUE_WIDTH-1:0] r_last;

    // Prime table memory
    logic [VALUE_WIDTH-1:0] r_table [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    // Decoded controls
    logic                   in_fire;
    logic                   out_free;
    logic                   sq_over;
    logic                   exhausted;
    logic                   div_start;
    logic                   rd_en;
    logic                   finish;
    logic                   store;
    t_rem_status            rem_status;
    logic [CNT_W+PS_W-1:0]  count_ext;

    tdpt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_status   (rem_status)
    );

    assign in_fire   = i_cand.valid && i_cand.ready;
    assign out_free  = !r_out_valid || o_res.ready;
    assign sq_over   = r_sq > {{VALUE_WIDTH{1'b0}}, r_n};
    assign exhausted = (r_idx == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_cand.data.candidate < FIRST_DIVISOR) ? S_FINISH : S_TEST;
                end
            end
            S_TEST: begin
                n_state = sq_over ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                if (rem_status.done) begin
                    n_state = rem_status.rem_zero ? S_FINISH : S_READ;
                end
            end
            S_READ: begin
                n_state = exhausted ? S_FINISH : S_LOAD;
            end
            S_LOAD: begin
                n_state = S_TEST;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_cand.ready = (r_state == S_IDLE);
        div_start    = (r_state == S_TEST) && !sq_over;
        rd_en        = (r_state == S_READ) && !exhausted;
        finish       = (r_state == S_FINISH) && out_free;
        store        = finish && r_verdict && !r_unknown
                       && (r_count < CNT_W'(TABLE_DEPTH))
                       && ((r_count == '0) || (r_n > r_last));
        n_count      = store ? r_count + 1'b1 : r_count;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance the working registers; r_idx points at the next table entry
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_n       <= i_cand.data.candidate;
            r_d       <= FIRST_DIVISOR;
            r_sq      <= FIRST_SQUARE;
            r_idx     <= '0;
            r_verdict <= 1'b0;
            r_unknown <= 1'b0;
        end
        if (r_state == S_TEST && sq_over) begin
            r_verdict <= 1'b1;
            r_unknown <= 1'b0;
        end
        if (r_state == S_DIV && rem_status.done) begin
            if (rem_status.rem_zero) begin
                r_verdict <= 1'b0;
            end
        end
        if (r_state == S_READ && exhausted) begin
            r_verdict <= 1'b1;
            r_unknown <= 1'b1;
        end
        if (r_state == S_LOAD) begin
            r_d   <= r_rdata;
            r_sq  <= {{VALUE_WIDTH{1'b0}}, r_rdata} * {{VALUE_WIDTH{1'b0}}, r_rdata};
            r_idx <= r_idx + 1'b1;
        end
        if (store) begin
            r_last <= r_n;
        end
    end

    // Table memory: reads stay below the count, the write goes at the count,
    // so a read and a write never meet on one entry
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_table[r_count[ADDR_W-1:0]] <= r_n;
        end
        if (rd_en) begin
            r_rdata <= r_table[r_idx[ADDR_W-1:0]];
        end
    end

    // Load the result register
    assign count_ext = {{PS_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out.is_prime      <= r_verdict;
            r_out.primes_stored <= count_ext[PS_W-1:0];
            r_out.undetermined  <= r_unknown;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Remainder unit reports only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_status.done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");

    // Table count grows by at most one per cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + 1'b1))
        else $error("table count jumped");

    // Table reads stay inside the filled part
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_idx < r_count))
        else $error("table read beyond stored primes");

    // An undetermined result always carries the prime verdict
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.undetermined) |-> r_out.is_prime)
        else $error("undetermined result without prime verdict");

endmodule

`default_nettype wire
